FILE: rtl/owbm_pkg.sv
package owbm_pkg;

  localparam int TIME_BITS_DEF = 10;
  localparam int CFG_W         = 10;
  localparam int CFG_COUNT     = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 16;

  // Fixed release times of the write slots, in microseconds.
  localparam int WR_ONE_RELEASE  = 54;
  localparam int WR_ZERO_RELEASE = 10;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_TAIL,
    PH_WR_LOW,
    PH_WR_REL,
    PH_RD_LOW,
    PH_RD_WAIT,
    PH_RD_REC
  } phase_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_RESET,
    CMD_WRITE,
    CMD_READ
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RST_LOW,
    CFG_PRES_WAIT,
    CFG_RST_TAIL,
    CFG_WR1_LOW,
    CFG_WR0_LOW,
    CFG_RD_LOW,
    CFG_RD_SAMPLE,
    CFG_RD_REC
  } cfg_idx_t;

  typedef logic [CFG_W-1:0] cfg_word_t;

  localparam cfg_word_t CFG_RESET_VAL [CFG_COUNT] = '{
    10'd480, 10'd70, 10'd410, 10'd6, 10'd60, 10'd2, 10'd10, 10'd45
  };

endpackage

FILE: rtl/onewire_bus_master.sv
// 1-Wire bus master, one request per microsecond tick.
// Throughput: one request per cycle while out_tready does not stall the output register;
// the whole tick (counter compare, phase changes, including chains of zero-length phases)
// is done between the input and output registers.
// Reset (rst_n low, synchronous): bus released, idle, timing registers back to defaults.
module onewire_bus_master #(
  parameter int TIME_BITS = owbm_pkg::TIME_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: [1:0] command, [9:2] write_data, [10] line_level, [15:11] zero
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [owbm_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata: [0] drive_low, [1] busy_res, [2] done_res, [10:3] read_data,
  // [11] presence, [12] rejected, [15:13] zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [owbm_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [owbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [owbm_pkg::CFG_W-1:0]         cfg_data
);
  import owbm_pkg::*;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
  localparam logic [TIME_BITS-1:0] WR1_REL  = TIME_BITS'(WR_ONE_RELEASE);
  localparam logic [TIME_BITS-1:0] WR0_REL  = TIME_BITS'(WR_ZERO_RELEASE);

  function automatic logic [TIME_BITS-1:0] clamp_time(input cfg_word_t t);
    if ({{TIME_BITS{1'b0}}, t} > {{CFG_W{1'b0}}, TIME_MAX}) begin
      return TIME_MAX;
    end
    return TIME_BITS'(t);
  endfunction

  cfg_word_t              cfg_r [CFG_COUNT];

  logic                   s1_valid_r;
  logic [IN_TDATA_W-1:0]  s1_data_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   advance;

  phase_t                 phase_r, phase_nxt;
  logic [TIME_BITS-1:0]   elapsed_r, elapsed_nxt;
  logic [2:0]             bit_r, bit_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic                   pres_r, pres_nxt;
  logic [7:0]             last_rd_r, last_rd_nxt;
  logic                   done_c, rej_c, drive_c;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_COUNT; i++) begin
        cfg_r[i] <= CFG_RESET_VAL[i];
      end
    end else if (cfg_valid) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  // Input register, processing step, output register.
  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata;
    end
  end

  always_comb begin
    cmd_t                 cmd;
    logic [7:0]           wdata;
    logic                 line;
    logic                 rd_all_zero;
    logic [3:0]           k;
    logic [TIME_BITS-1:0] dur;
    phase_t               ph;
    logic [TIME_BITS-1:0] el;
    logic [2:0]           bi;
    logic [7:0]           sb;

    cmd   = cmd_t'(s1_data_r[1:0]);
    wdata = s1_data_r[9:2];
    line  = s1_data_r[10];
    rd_all_zero = (cfg_r[CFG_RD_LOW] == '0) && (cfg_r[CFG_RD_SAMPLE] == '0) &&
                  (cfg_r[CFG_RD_REC] == '0);

    ph          = phase_r;
    el          = elapsed_r;
    bi          = bit_r;
    sb          = shift_r;
    pres_nxt    = pres_r;
    last_rd_nxt = last_rd_r;
    done_c      = 1'b0;
    rej_c       = 1'b0;
    drive_c     = 1'b0;
    k           = '0;
    dur         = '0;

    if (cmd != CMD_TICK) begin
      if (ph != PH_IDLE) begin
        rej_c = 1'b1;
      end else begin
        el = '0;
        bi = '0;
        case (cmd)
          CMD_RESET: ph = PH_RST_LOW;
          CMD_WRITE: begin
            ph = PH_WR_LOW;
            sb = wdata;
          end
          default: begin
            ph = PH_RD_LOW;
            sb = '0;
          end
        endcase
      end
    end

    if ((ph inside {PH_RD_LOW, PH_RD_WAIT, PH_RD_REC}) && rd_all_zero) begin
      // Every read phase is zero long: the rest of the byte is sampled in this
      // tick, each remaining bit taking the same line level.
      k  = (ph == PH_RD_REC) ? (4'd7 - {1'b0, bi}) : (4'd8 - {1'b0, bi});
      sb = (sb >> k) | (line ? ~(8'hFF >> k) : 8'h00);
      last_rd_nxt = sb;
      ph     = PH_IDLE;
      el     = '0;
      bi     = '0;
      done_c = 1'b1;
    end else begin
      // Otherwise at most three phases can end within one tick.
      for (int s = 0; s < 3; s++) begin
        case (ph)
          PH_RST_LOW:  dur = clamp_time(cfg_r[CFG_RST_LOW]);
          PH_RST_WAIT: dur = clamp_time(cfg_r[CFG_PRES_WAIT]);
          PH_RST_TAIL: dur = clamp_time(cfg_r[CFG_RST_TAIL]);
          PH_WR_LOW:   dur = clamp_time(sb[bi] ? cfg_r[CFG_WR1_LOW] : cfg_r[CFG_WR0_LOW]);
          PH_WR_REL:   dur = sb[bi] ? WR1_REL : WR0_REL;
          PH_RD_LOW:   dur = clamp_time(cfg_r[CFG_RD_LOW]);
          PH_RD_WAIT:  dur = clamp_time(cfg_r[CFG_RD_SAMPLE]);
          PH_RD_REC:   dur = clamp_time(cfg_r[CFG_RD_REC]);
          default:     dur = '0;
        endcase
        if (ph != PH_IDLE && el >= dur) begin
          el = '0;
          case (ph)
            PH_RST_LOW: ph = PH_RST_WAIT;
            PH_RST_WAIT: begin
              pres_nxt = !line;
              ph       = PH_RST_TAIL;
            end
            PH_WR_LOW: ph = PH_WR_REL;
            PH_WR_REL: begin
              if (bi == 3'd7) begin
                ph     = PH_IDLE;
                bi     = '0;
                done_c = 1'b1;
              end else begin
                bi = bi + 3'd1;
                ph = PH_WR_LOW;
              end
            end
            PH_RD_LOW: ph = PH_RD_WAIT;
            PH_RD_WAIT: begin
              sb = {line, sb[7:1]};
              ph = PH_RD_REC;
            end
            PH_RD_REC: begin
              if (bi == 3'd7) begin
                last_rd_nxt = sb;
                ph     = PH_IDLE;
                bi     = '0;
                done_c = 1'b1;
              end else begin
                bi = bi + 3'd1;
                ph = PH_RD_LOW;
              end
            end
            default: begin
              ph     = PH_IDLE;
              bi     = '0;
              done_c = 1'b1;
            end
          endcase
        end
      end
    end

    if (ph != PH_IDLE) begin
      drive_c = (ph == PH_RST_LOW) || (ph == PH_WR_LOW) || (ph == PH_RD_LOW);
      if (el < TIME_MAX) begin
        el = el + 1'b1;
      end
    end

    phase_nxt   = ph;
    elapsed_nxt = el;
    bit_nxt     = bi;
    shift_nxt   = sb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      elapsed_r   <= '0;
      bit_r       <= '0;
      shift_r     <= '0;
      pres_r      <= 1'b0;
      last_rd_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        phase_r   <= phase_nxt;
        elapsed_r <= elapsed_nxt;
        bit_r     <= bit_nxt;
        shift_r   <= shift_nxt;
        pres_r    <= pres_nxt;
        last_rd_r <= last_rd_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {3'b000, rej_c, pres_nxt, last_rd_nxt, done_c,
                     (phase_nxt != PH_IDLE), drive_c};
    end
  end

  // A finished operation never reports itself as still running.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[2] && out_data_r[1]))
    else $error("done and busy set in the same result");

  // The bus is only pulled low while an operation runs.
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[0] |-> out_data_r[1])
    else $error("bus driven low while idle");

  // A request is only flagged as rejected when an operation was already running.
  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    advance && rej_c |-> phase_r != PH_IDLE)
    else $error("request rejected while idle");

  // Idle leaves no bit position or elapsed count behind.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> bit_r == '0 && elapsed_r == '0)
    else $error("idle with stale slot state");

  // The busy flag in a result matches the phase the block moved into.
  a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_data_r[1] == (phase_r != PH_IDLE))
    else $error("busy flag disagrees with phase");

endmodule

FILE: bench/tb_onewire_bus_master.sv
module tb_onewire_bus_master;
  import owbm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_TICKS   = 60;
  localparam int LINE_LOW       = 0;
  localparam int LINE_HIGH      = 1;
  localparam int LINE_RANDOM    = 2;

  localparam cfg_word_t CFG_LOW [CFG_COUNT] = '{
    10'd1, 10'd1, 10'd0, 10'd1, 10'd1, 10'd1, 10'd0, 10'd0
  };
  localparam cfg_word_t CFG_ZERO [CFG_COUNT] = '{
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0
  };

  // Packed so that the command lands in the lowest bits, as on in_tdata.
  typedef struct packed {
    logic       line;
    logic [7:0] wdata;
    cmd_t       cmd;
  } tick_t;

  // Packed so that drive_low lands in bit 0, as on out_tdata.
  typedef struct packed {
    logic       rejected;
    logic       presence;
    logic [7:0] read_data;
    logic       done;
    logic       busy;
    logic       drive_low;
  } bus_status_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_W-1:0]       cfg_data   = '0;

  onewire_bus_master DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  tick_t       tick_queue [$];
  bus_status_t status_queue [$];
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          ticks_queued   = 0;
  int          ticks_checked  = 0;
  int          ops_completed  = 0;
  int          refusals_seen  = 0;
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;

  // Shadow of the bus master state and its timing registers.
  cfg_word_t   bus_cfg [CFG_COUNT];
  phase_t      slot_phase;
  logic [9:0]  slot_us;
  logic [2:0]  bit_pos;
  logic [7:0]  shift_reg;
  logic        seen_presence;
  logic [7:0]  read_byte;

  // Timing registers are as wide as the counter, so no clamping is needed.
  function automatic logic [9:0] slot_length(phase_t ph);
    case (ph)
      PH_RST_LOW:  return bus_cfg[CFG_RST_LOW];
      PH_RST_WAIT: return bus_cfg[CFG_PRES_WAIT];
      PH_RST_TAIL: return bus_cfg[CFG_RST_TAIL];
      PH_WR_LOW:   return shift_reg[bit_pos] ? bus_cfg[CFG_WR1_LOW] : bus_cfg[CFG_WR0_LOW];
      PH_WR_REL:   return shift_reg[bit_pos] ? 10'(WR_ONE_RELEASE) : 10'(WR_ZERO_RELEASE);
      PH_RD_LOW:   return bus_cfg[CFG_RD_LOW];
      PH_RD_WAIT:  return bus_cfg[CFG_RD_SAMPLE];
      PH_RD_REC:   return bus_cfg[CFG_RD_REC];
      default:     return 10'd0;
    endcase
  endfunction

  task automatic advance_bus_model(tick_t t);
    bus_status_t st;
    logic        finished;
    st = '0;
    if (t.cmd != CMD_TICK) begin
      if (slot_phase != PH_IDLE) begin
        st.rejected = 1'b1;
      end else begin
        slot_us = '0;
        bit_pos = '0;
        case (t.cmd)
          CMD_RESET: slot_phase = PH_RST_LOW;
          CMD_WRITE: begin
            shift_reg  = t.wdata;
            slot_phase = PH_WR_LOW;
          end
          default: begin
            shift_reg  = '0;
            slot_phase = PH_RD_LOW;
          end
        endcase
      end
    end
    // Phases of zero length fall through within the same tick.
    while (slot_phase != PH_IDLE && slot_us >= slot_length(slot_phase)) begin
      slot_us  = '0;
      finished = 1'b0;
      case (slot_phase)
        PH_RST_LOW:  slot_phase = PH_RST_WAIT;
        PH_RST_WAIT: begin
          seen_presence = !t.line;
          slot_phase    = PH_RST_TAIL;
        end
        PH_WR_LOW:   slot_phase = PH_WR_REL;
        PH_WR_REL: begin
          if (bit_pos == 3'd7) begin
            finished = 1'b1;
          end else begin
            bit_pos++;
            slot_phase = PH_WR_LOW;
          end
        end
        PH_RD_LOW:   slot_phase = PH_RD_WAIT;
        PH_RD_WAIT: begin
          shift_reg  = {t.line, shift_reg[7:1]};
          slot_phase = PH_RD_REC;
        end
        PH_RD_REC: begin
          if (bit_pos == 3'd7) begin
            read_byte = shift_reg;
            finished  = 1'b1;
          end else begin
            bit_pos++;
            slot_phase = PH_RD_LOW;
          end
        end
        default:     finished = 1'b1;
      endcase
      if (finished) begin
        slot_phase = PH_IDLE;
        bit_pos    = '0;
        st.done    = 1'b1;
      end
    end
    if (slot_phase != PH_IDLE) begin
      st.drive_low = (slot_phase == PH_RST_LOW) || (slot_phase == PH_WR_LOW) ||
                     (slot_phase == PH_RD_LOW);
      if (slot_us != '1) slot_us++;
    end
    st.busy      = (slot_phase != PH_IDLE);
    st.read_data = read_byte;
    st.presence  = seen_presence;
    status_queue.push_back(st);
  endtask

  // Driver: the prediction is made when the request is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) advance_bus_model(tick_t'(in_tdata[10:0]));
      if (!in_tvalid || in_tready) begin
        if (tick_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata  <= {5'b0, tick_queue.pop_front()};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  bus_status_t want_st;
  bus_status_t got_st;

  // Monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_st = bus_status_t'(out_tdata[12:0]);
      if (status_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result %h with no request outstanding", out_tdata);
      end else begin
        want_st = status_queue.pop_front();
        ticks_checked++;
        if (want_st.done) ops_completed++;
        if (want_st.rejected) refusals_seen++;
        if (got_st.drive_low !== want_st.drive_low || got_st.busy !== want_st.busy ||
            got_st.done !== want_st.done || got_st.read_data !== want_st.read_data ||
            got_st.presence !== want_st.presence || got_st.rejected !== want_st.rejected)
        begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("tick %0d: expected drv=%b busy=%b done=%b rd=%h pres=%b rej=%b",
                     ticks_checked, want_st.drive_low, want_st.busy, want_st.done,
                     want_st.read_data, want_st.presence, want_st.rejected);
            $display("         got      drv=%b busy=%b done=%b rd=%h pres=%b rej=%b",
                     got_st.drive_low, got_st.busy, got_st.done,
                     got_st.read_data, got_st.presence, got_st.rejected);
          end
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_tick(cmd_t c, logic [7:0] d, int line_mode);
    tick_t t;
    t.cmd   = c;
    t.wdata = d;
    t.line  = (line_mode == LINE_RANDOM) ? 1'($urandom_range(1)) : line_mode[0];
    tick_queue.push_back(t);
    ticks_queued++;
  endtask

  // Issues one command and keeps ticking until the model says the bus is idle.
  // The ticks that follow may carry stray commands, which the block must refuse while busy.
  task automatic run_op(cmd_t c, logic [7:0] d, int line_mode, int stray_pct);
    int   k;
    cmd_t sc;
    push_tick(c, d, line_mode);
    do begin
      for (k = 0; k < 8; k++) begin
        sc = ($urandom_range(99) < stray_pct) ? cmd_t'($urandom_range(3, 1)) : CMD_TICK;
        push_tick(sc, 8'($urandom), line_mode);
      end
      do @(negedge clk); while (tick_queue.size() > 1);
    end while (slot_phase != PH_IDLE);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (tick_queue.size() != 0 || status_queue.size() != 0 || in_tvalid);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_timing(cfg_word_t v [CFG_COUNT]);
    int i;
    wait_drained();
    for (i = 0; i < CFG_COUNT; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= v[i];
      do @(posedge clk); while (!cfg_ready);
      bus_cfg[i] = v[i];
    end
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_op(int stray_pct);
    int   r;
    int   lm;
    cmd_t c;
    r  = $urandom_range(99);
    c  = (r < 35) ? CMD_RESET : ((r < 75) ? CMD_READ : CMD_WRITE);
    lm = ($urandom_range(9) < 2) ? $urandom_range(1) : LINE_RANDOM;
    run_op(c, 8'($urandom), lm, stray_pct);
  endtask

  task automatic random_phase(int send_pct, int recv_pct);
    cfg_word_t v [CFG_COUNT];
    int        i;
    int        start;
    for (i = 0; i < CFG_COUNT; i++) v[i] = cfg_word_t'($urandom_range(5));
    load_timing(v);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start = ticks_queued;
    while (ticks_queued - start < RANDOM_TICKS) begin
      random_op(8);
      repeat ($urandom_range(3)) push_tick(CMD_TICK, 8'($urandom), LINE_RANDOM);
    end
  endtask

  initial begin
    bus_cfg       = CFG_RESET_VAL;
    slot_phase    = PH_IDLE;
    slot_us       = '0;
    bit_pos       = '0;
    shift_reg     = '0;
    seen_presence = 1'b0;
    read_byte     = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // The first read slot runs on the power-on timings; the short timings
    // then take over while the read is still under way.
    push_tick(CMD_READ, 8'h00, LINE_RANDOM);
    repeat (63) push_tick(CMD_TICK, 8'($urandom), LINE_RANDOM);
    load_timing(CFG_LOW);
    run_op(CMD_TICK, 8'h00, LINE_RANDOM, 0);

    // Shortest timings, with zero-length tails, samples and recoveries.
    run_op(CMD_RESET, 8'h00, LINE_LOW, 0);
    run_op(CMD_RESET, 8'h00, LINE_HIGH, 0);
    push_tick(CMD_TICK, 8'hFF, LINE_LOW);
    run_op(CMD_WRITE, 8'h00, LINE_HIGH, 0);
    run_op(CMD_WRITE, 8'h81, LINE_RANDOM, 0);
    run_op(CMD_READ, 8'h00, LINE_HIGH, 0);
    run_op(CMD_READ, 8'hFF, LINE_LOW, 0);
    run_op(CMD_READ, 8'h3C, LINE_RANDOM, 0);
    run_op(CMD_READ, 8'h00, LINE_RANDOM, 25);
    run_op(CMD_WRITE, 8'h12, LINE_RANDOM, 25);
    run_op(CMD_RESET, 8'h00, LINE_RANDOM, 25);

    // Every timing zero: a reset or a whole read byte finishes within one tick.
    load_timing(CFG_ZERO);
    run_op(CMD_RESET, 8'h00, LINE_LOW, 0);
    run_op(CMD_READ, 8'h00, LINE_RANDOM, 0);
    run_op(CMD_READ, 8'h00, LINE_HIGH, 0);
    run_op(CMD_WRITE, 8'h00, LINE_RANDOM, 0);
    run_op(CMD_READ, 8'h00, LINE_RANDOM, 25);

    random_phase(0, 0);
    random_phase(59, 0);
    random_phase(0, 59);
    random_phase(13, 13);

    wait_drained();
    $display("Checked %0d ticks under power-on, short, zero-length and random timings.",
             ticks_checked);
    $display("%0d bus operations completed, %0d commands refused while busy.",
             ops_completed, refusals_seen);
    if (mismatch_count == 0 && status_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
